@@ hw/rtl/rtks_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtks_pkg: shared types and codes for the running top-K sum block
// Payload structs, controller/datapath command and status bundles, codes.
// ----------------------------------------------------------------------------
package rtks_pkg;

  localparam int IN_VALUE_W = 32;
  localparam int SUM_W      = 38;
  localparam int COUNT_W    = 7;

  localparam logic [COUNT_W-1:0] TOP_COUNT_RESET = 7'd1;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // memory address = pos minus this amount
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;

  typedef struct packed {
    logic                         req_type;
    logic signed [IN_VALUE_W-1:0] value;
  } rtks_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] top_sum;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      held_count;
  } rtks_out_t;

  typedef struct packed {
    logic       load;
    logic       pos_count;
    logic       pos_dec;
    logic       pos_inc;
    logic       rd_en;
    logic [1:0] rd_sub;
    logic       wr_en;
    logic       wr_rdata;
    logic [1:0] wr_sub;
    logic       count_inc;
    logic       count_dec;
    logic       status_set;
    logic [1:0] status_code;
    logic       sum_clear;
    logic       sum_add;
    logic       left_load;
    logic       left_dec;
    logic       result_load;
  } rtks_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic count_zero;
    logic full;
    logic pos_zero;
    logic pos_one;
    logic pos_eq_count;
    logic left_zero;
    logic less;
    logic equal;
  } rtks_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/rtks_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtks_dp: datapath of the running top-K sum block
// Sorted value memory, pointers, entry count, accumulator and result register.
// ----------------------------------------------------------------------------
module rtks_dp #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  rtks_pkg::rtks_in_t       in_data,
  input  wire                            cfg_we,
  input  wire  [rtks_pkg::COUNT_W-1:0]   cfg_data,
  input  wire  rtks_pkg::rtks_cmd_t      cmd,
  output rtks_pkg::rtks_stat_t           stat,
  output rtks_pkg::rtks_out_t            out_data
);
  import rtks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] req_val;
  logic                  req_remove;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         count;
  logic [CW-1:0]         left;
  logic [SUM_W-1:0]      sum;
  logic [1:0]            status_r;
  logic [COUNT_W-1:0]    top_count;

  logic [CW-1:0]         rd_pt;
  logic [CW-1:0]         wr_pt;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  assign rd_pt   = pos - CW'(cmd.rd_sub);
  assign wr_pt   = pos - CW'(cmd.wr_sub);
  assign rd_addr = rd_pt[AW-1:0];
  assign wr_addr = wr_pt[AW-1:0];
  assign wr_data = cmd.wr_rdata ? rdata : req_val;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_remove <= (in_data.req_type == REQ_REMOVE);
      req_val    <= VALUE_BITS'($unsigned(in_data.value));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      count     <= '0;
      left      <= '0;
      sum       <= '0;
      top_count <= TOP_COUNT_RESET;
    end else begin
      if (cfg_we) begin
        top_count <= cfg_data;
      end

      // removes scan upward from zero, inserts walk down from the top
      if (cmd.load) begin
        pos <= (in_data.req_type == REQ_REMOVE) ? '0 : count;
      end else if (cmd.pos_count) begin
        pos <= count;
      end else if (cmd.pos_dec) begin
        pos <= pos - 1'b1;
      end else if (cmd.pos_inc) begin
        pos <= pos + 1'b1;
      end

      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end

      if (cmd.left_load) begin
        left <= (MW'(top_count) < MW'(count)) ? CW'(top_count) : count;
      end else if (cmd.left_dec) begin
        left <= left - 1'b1;
      end

      if (cmd.sum_clear) begin
        sum <= '0;
      end else if (cmd.sum_add) begin
        sum <= sum + SUM_W'($signed(rdata));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= STAT_DONE;
    end else if (cmd.status_set) begin
      status_r <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.top_sum    <= sum;
      out_data.status     <= status_r;
      out_data.held_count <= COUNT_W'(count);
    end
  end

  always_comb begin
    stat.is_remove    = req_remove;
    stat.count_zero   = (count == '0);
    stat.full         = (count == CW'(CAPACITY));
    stat.pos_zero     = (pos == '0);
    stat.pos_one      = (pos == CW'(1));
    stat.pos_eq_count = (pos == count);
    stat.left_zero    = (left == '0);
    stat.less         = ($signed(req_val) < $signed(rdata));
    stat.equal        = (req_val == rdata);
  end

endmodule
`default_nettype wire

@@ hw/rtl/rtks_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtks_ctrl: sequencer of the running top-K sum block
// Steps insert, remove and summing walks over the memory; owns out_valid.
// ----------------------------------------------------------------------------
module rtks_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wire rtks_pkg::rtks_stat_t stat,
  output rtks_pkg::rtks_cmd_t  cmd
);
  import rtks_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DISPATCH  = 12'b0000_0000_0010,
    S_INS_FIRST = 12'b0000_0000_0100,
    S_INS_LOOP  = 12'b0000_0000_1000,
    S_INS_LAST  = 12'b0000_0001_0000,
    S_REM_FIRST = 12'b0000_0010_0000,
    S_REM_SCAN  = 12'b0000_0100_0000,
    S_REM_SHIFT = 12'b0000_1000_0000,
    S_SUM_INIT  = 12'b0001_0000_0000,
    S_SUM_FIRST = 12'b0010_0000_0000,
    S_SUM_LOOP  = 12'b0100_0000_0000,
    S_RESULT    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = stat.is_remove ? S_REM_FIRST : S_INS_FIRST;
      end
      S_INS_FIRST: begin
        if (stat.full) begin
          cmd.status_set  = 1'b1;
          cmd.status_code = STAT_FULL;
          state_next      = S_SUM_INIT;
        end else if (stat.pos_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sub    = SUB_0;
          cmd.count_inc = 1'b1;
          state_next    = S_SUM_INIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sub = SUB_1;
          state_next = S_INS_LOOP;
        end
      end
      S_INS_LOOP: begin
        // rdata holds entry pos-1; shift it up or drop the value in at pos
        cmd.wr_en  = 1'b1;
        cmd.wr_sub = SUB_0;
        if (stat.less) begin
          cmd.wr_rdata = 1'b1;
          cmd.pos_dec  = 1'b1;
          if (stat.pos_one) begin
            state_next = S_INS_LAST;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sub = SUB_2;
          end
        end else begin
          cmd.count_inc = 1'b1;
          state_next    = S_SUM_INIT;
        end
      end
      S_INS_LAST: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sub    = SUB_0;
        cmd.count_inc = 1'b1;
        state_next    = S_SUM_INIT;
      end
      S_REM_FIRST: begin
        if (stat.count_zero) begin
          cmd.status_set  = 1'b1;
          cmd.status_code = STAT_NOT_FOUND;
          state_next      = S_SUM_INIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sub  = SUB_0;
          cmd.pos_inc = 1'b1;
          state_next  = S_REM_SCAN;
        end
      end
      S_REM_SCAN: begin
        // rdata holds entry pos-1
        if (stat.pos_eq_count) begin
          if (stat.equal) begin
            cmd.count_dec = 1'b1;
          end else begin
            cmd.status_set  = 1'b1;
            cmd.status_code = STAT_NOT_FOUND;
          end
          state_next = S_SUM_INIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sub  = SUB_0;
          cmd.pos_inc = 1'b1;
          if (stat.equal) begin
            state_next = S_REM_SHIFT;
          end
        end
      end
      S_REM_SHIFT: begin
        // entry pos-1 moves down to pos-2
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.wr_sub   = SUB_2;
        if (stat.pos_eq_count) begin
          cmd.count_dec = 1'b1;
          state_next    = S_SUM_INIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sub  = SUB_0;
          cmd.pos_inc = 1'b1;
        end
      end
      S_SUM_INIT: begin
        cmd.sum_clear = 1'b1;
        cmd.pos_count = 1'b1;
        cmd.left_load = 1'b1;
        state_next    = S_SUM_FIRST;
      end
      S_SUM_FIRST: begin
        if (stat.left_zero) begin
          state_next = S_RESULT;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sub   = SUB_1;
          cmd.pos_dec  = 1'b1;
          cmd.left_dec = 1'b1;
          state_next   = S_SUM_LOOP;
        end
      end
      S_SUM_LOOP: begin
        cmd.sum_add = 1'b1;
        if (stat.left_zero) begin
          state_next = S_RESULT;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sub   = SUB_1;
          cmd.pos_dec  = 1'b1;
          cmd.left_dec = 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/running_top_k_sum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// running_top_k_sum: sorted multiset with running sum of the K largest values
// Each request inserts a value or removes one copy; every request returns one
// result with the top-K sum, a status code and the number of values held.
//
// Channels: in_valid/in_stall/in_data carries requests, out_valid/out_stall/
// out_data carries results; a transaction completes on a clock edge with valid
// high and stall low. cfg_valid/cfg_ready/cfg_data writes top_count (K);
// cfg_ready is always high, write only while no request is in flight.
// Flow: one request at a time. A request first walks the sorted memory: an
// insert walks down over the entries above the insert point (no walk into an
// empty or full store), a remove scans every entry held; then the summing
// pass reads min(K, held) entries, one entry per cycle from the top.
// The result sits in an output register; in_stall drops again as soon as it
// is loaded, so the next request is taken while a result waits. If out_stall
// holds the previous result when a new one is ready, the block waits.
// Reset (rst, synchronous): store empty, K = 1, no result pending.
// ----------------------------------------------------------------------------
module running_top_k_sum #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  rtks_pkg::rtks_in_t      in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output rtks_pkg::rtks_out_t           out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [rtks_pkg::COUNT_W-1:0]  cfg_data
);
  import rtks_pkg::*;

  rtks_cmd_t  cmd;
  rtks_stat_t stat;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  rtks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtks_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
